// ----- sv/spi_nand_dump_controller_assert.svh -----
// Assertion macros used by the top-level RTL
`ifndef SPI_NAND_DUMP_CONTROLLER_ASSERT_SVH
`define SPI_NAND_DUMP_CONTROLLER_ASSERT_SVH
// implication checked every clock outside reset
`define SND_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SND_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- sv/snd_pkg.sv -----
// Package: constants and types for the SPI NAND dump controller
package snd_pkg;
    localparam int PAGE_BYTES   = 2048;
    localparam int DEVICE_BYTES = 134217728;
    localparam int BUFFER_BYTES = 61440;
    localparam int COL_W  = $clog2(PAGE_BYTES);
    localparam int ADDR_W = 28;
    localparam int PBL_W  = COL_W + 2;

    localparam logic [7:0] CMD_ID     = 8'h9F;
    localparam logic [7:0] CMD_LOAD   = 8'h13;
    localparam logic [7:0] CMD_STATUS = 8'h0F;
    localparam logic [7:0] REG_STATUS = 8'hC0;
    localparam logic [7:0] CMD_CACHE  = 8'h3B;
    localparam logic [7:0] ID_A       = 8'hC8;
    localparam logic [7:0] ID_B       = 8'h98;

    typedef enum logic [2:0] {
        PH_IDLE, PH_CMD, PH_READ, PH_GAP, PH_WAIT, PH_FILL
    } t_phase;
    typedef enum logic [1:0] {OP_ID, OP_LOAD, OP_STATUS, OP_CACHE} t_op;
    typedef enum logic [1:0] {RS_IDLE, RS_RUN, RS_DONE, RS_ERR} t_run;
    typedef enum logic [1:0] {ER_OK, ER_NODET, ER_TIMEOUT} t_err;
    typedef enum logic [2:0] {
        RG_START, RG_COUNT, RG_BIAS, RG_HALF, RG_WAIT, RG_LIMIT
    } t_reg;

    typedef struct packed {
        logic [26:0] start_address;
        logic [15:0] byte_count;
        logic [26:0] read_bias;
        logic [7:0]  half_period_ticks;
        logic [23:0] poll_wait_ticks;
        logic [9:0]  poll_limit;
    } t_cfg;
endpackage

// ----- sv/snd_regs.sv -----
// APB register file for the SPI NAND dump controller
module snd_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output snd_pkg::t_cfg    o_cfg
);
    snd_pkg::t_cfg r_cfg;
    logic [2:0] w_idx;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_address     <= '0;
            r_cfg.byte_count        <= '0;
            r_cfg.read_bias         <= 27'd131072;
            r_cfg.half_period_ticks <= 8'd4;
            r_cfg.poll_wait_ticks   <= 24'd40000;
            r_cfg.poll_limit        <= 10'd1000;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                snd_pkg::RG_START: r_cfg.start_address     <= pwdata[26:0];
                snd_pkg::RG_COUNT: r_cfg.byte_count        <= pwdata[15:0];
                snd_pkg::RG_BIAS:  r_cfg.read_bias         <= pwdata[26:0];
                snd_pkg::RG_HALF:  r_cfg.half_period_ticks <= pwdata[7:0];
                snd_pkg::RG_WAIT:  r_cfg.poll_wait_ticks   <= pwdata[23:0];
                snd_pkg::RG_LIMIT: r_cfg.poll_limit        <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            snd_pkg::RG_START: prdata = {5'd0, r_cfg.start_address};
            snd_pkg::RG_COUNT: prdata = {16'd0, r_cfg.byte_count};
            snd_pkg::RG_BIAS:  prdata = {5'd0, r_cfg.read_bias};
            snd_pkg::RG_HALF:  prdata = {24'd0, r_cfg.half_period_ticks};
            snd_pkg::RG_WAIT:  prdata = {8'd0, r_cfg.poll_wait_ticks};
            snd_pkg::RG_LIMIT: prdata = {22'd0, r_cfg.poll_limit};
            default:           prdata = '0;
        endcase
    end
endmodule

// ----- sv/spi_nand_dump_controller.sv -----
// Top level: SPI NAND dump controller, one tick item in, one status item out
// Each input item is one clock tick of the flash interface: it samples the data lines
// and the start request, and yields one output item with the pin levels during that
// tick, an optional delivered byte with its offset, and the run status. One item is
// taken every cycle; the result sits in an output register that stalls only when the
// output side holds off. Input tdata: [0] start_req, [1] io0_in, [2] io1_in. Output
// tdata from bit 0: chip_select_n, serial_clock, io1_out, io1_drive, byte_valid,
// byte_value[8], byte_offset[16], run_state[2], error_code[2], last_status[8],
// poll_count[10], bytes_read[16], zero pad to 72 bits.
module spi_nand_dump_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // start_req, io0_in, io1_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // chip_select_n, serial_clock, io1_out, io1_drive,
                                        // byte_valid, byte_value, byte_offset, run_state,
                                        // error_code, last_status, poll_count, bytes_read
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    `include "spi_nand_dump_controller_assert.svh"
    localparam int AW = snd_pkg::ADDR_W;
    localparam int CW = snd_pkg::COL_W;
    localparam int PW = snd_pkg::PBL_W;

    snd_pkg::t_cfg cfg;
    snd_regs u_regs (.i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
                     .prdata, .pready, .o_cfg(cfg));

    snd_pkg::t_phase r_ph, n_ph;
    snd_pkg::t_op    r_op, n_op;
    logic [7:0]  r_sh, n_sh, r_div, n_div, r_stb, n_stb, r_last, n_last;
    logic [3:0]  r_bit, n_bit;
    logic [2:0]  r_cbi, n_cbi;
    logic [23:0] r_wait, n_wait;
    logic [AW-1:0] r_addr, n_addr;
    logic [15:0] r_rem, n_rem, r_tot, n_tot;
    logic [PW-1:0] r_pbl, n_pbl, r_chunk, n_chunk;
    logic [9:0]  r_retry, n_retry, r_pcnt, n_pcnt;
    logic [1:0]  r_att, n_att, r_rs, n_rs, r_err, n_err, r_xi, n_xi;
    logic [15:0] r_row, n_row;
    logic        r_sec, n_sec;
    logic [12:0] r_cxl, n_cxl;
    logic        ev_v;
    logic [7:0]  ev_val;
    logic [15:0] ev_off;
    logic        o_cs, o_sck, o_io1, o_drv;
    logic        take;
    logic [71:0] r_out;
    logic        r_ov;

    assign take = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_ov || m_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    function automatic logic [7:0] cmd_byte(snd_pkg::t_op op, logic [1:0] idx,
                                            logic [15:0] row, logic [CW-1:0] col);
        logic [15:0] c16;
        c16 = 16'(col);
        case (op)
            snd_pkg::OP_ID:     return idx == 2'd0 ? snd_pkg::CMD_ID : 8'h00;
            snd_pkg::OP_LOAD: begin
                case (idx)
                    2'd0:    return snd_pkg::CMD_LOAD;
                    2'd1:    return 8'h00;
                    2'd2:    return row[15:8];
                    default: return row[7:0];
                endcase
            end
            snd_pkg::OP_STATUS: return idx == 2'd0 ? snd_pkg::CMD_STATUS : snd_pkg::REG_STATUS;
            default: begin
                case (idx)
                    2'd0:    return snd_pkg::CMD_CACHE;
                    2'd1:    return c16[15:8];
                    2'd2:    return c16[7:0];
                    default: return 8'h00;
                endcase
            end
        endcase
    endfunction

    logic st, io0, io1;
    logic [7:0] hl;
    assign st  = s_axis_tdata[0];
    assign io0 = s_axis_tdata[1];
    assign io1 = s_axis_tdata[2];
    assign hl  = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;

    always_comb begin
        logic legacy, dual, ok, np, adv, tx, poll;
        logic [AW-1:0] want, addr_np;
        logic [15:0] rem_np;
        logic [PW-1:0] ch;
        logic [2:0] ccount;
        snd_pkg::t_op tx_op;
        logic [12:0] tx_n;
        logic [7:0] bv;
        n_ph = r_ph; n_op = r_op; n_sh = r_sh; n_div = r_div; n_stb = r_stb;
        n_last = r_last; n_bit = r_bit; n_cbi = r_cbi; n_wait = r_wait;
        n_addr = r_addr; n_rem = r_rem; n_tot = r_tot; n_pbl = r_pbl; n_chunk = r_chunk;
        n_retry = r_retry; n_pcnt = r_pcnt; n_att = r_att; n_rs = r_rs; n_err = r_err;
        n_xi = r_xi; n_row = r_row; n_sec = r_sec; n_cxl = r_cxl;
        ev_v = 1'b0; ev_val = '0; ev_off = '0;
        np = 1'b0; adv = 1'b0; tx = 1'b0; poll = 1'b0;
        tx_op = snd_pkg::OP_ID; tx_n = '0; ok = 1'b0;
        legacy = (r_op == snd_pkg::OP_ID) && (r_att == 2'd2);
        dual = (r_op == snd_pkg::OP_CACHE);
        ccount = (r_op == snd_pkg::OP_ID) ? (r_att == 2'd2 ? 3'd2 : 3'd1) :
                 (r_op == snd_pkg::OP_STATUS) ? 3'd2 : 3'd4;
        bv = '0; want = '0; addr_np = r_addr; rem_np = r_rem; ch = '0;

        o_cs  = !(r_ph == snd_pkg::PH_CMD || r_ph == snd_pkg::PH_READ);
        o_sck = !o_cs && r_sec;
        o_io1 = (r_ph == snd_pkg::PH_CMD) && r_sh[7];
        o_drv = !((r_ph == snd_pkg::PH_READ) && dual);

        case (r_ph)
            snd_pkg::PH_IDLE: begin
                if (st) begin
                    n_rs = snd_pkg::RS_RUN; n_err = snd_pkg::ER_OK; n_last = '0;
                    n_pcnt = '0; n_tot = '0; n_retry = '0; n_stb = '0; n_att = '0;
                    addr_np = AW'(cfg.start_address);
                    n_addr = addr_np;
                    n_rem = (cfg.byte_count > 16'(snd_pkg::BUFFER_BYTES)) ?
                            16'(snd_pkg::BUFFER_BYTES) : cfg.byte_count;
                    tx = 1'b1; tx_op = snd_pkg::OP_ID; tx_n = 13'd3;
                end
            end
            snd_pkg::PH_CMD, snd_pkg::PH_READ: begin
                n_div = r_div + 8'd1;
                if (n_div >= hl) begin
                    n_div = '0;
                    if (!r_sec) begin
                        if (r_ph == snd_pkg::PH_READ && legacy) n_sh = {r_sh[6:0], io0};
                        n_sec = 1'b1;
                    end else begin
                        n_sec = 1'b0;
                        if (r_ph == snd_pkg::PH_CMD) begin
                            n_sh = {r_sh[6:0], 1'b0};
                            n_bit = r_bit + 4'd1;
                            if (n_bit == 4'd8) begin
                                n_bit = '0;
                                n_cbi = r_cbi + 3'd1;
                                if (n_cbi < ccount)
                                    n_sh = cmd_byte(r_op, n_cbi[1:0], r_row, r_addr[CW-1:0]);
                                else if (r_cxl == '0) begin
                                    n_ph = snd_pkg::PH_GAP;
                                end else begin
                                    n_ph = snd_pkg::PH_READ; n_sh = '0;
                                end
                            end
                        end else begin
                            if (dual) bv = {r_sh[5:0], io0, io1};
                            else if (!legacy) bv = {r_sh[6:0], io0};
                            else bv = r_sh;
                            n_sh = bv;
                            n_bit = r_bit + 4'd1;
                            if (n_bit == (dual ? 4'd4 : 4'd8)) begin
                                n_bit = '0; n_sh = '0;
                                n_cxl = r_cxl - 13'd1;
                                n_xi = r_xi + 2'd1;
                                if (r_op == snd_pkg::OP_ID) begin
                                    if (r_xi == 2'd0) begin n_stb = bv; n_last = bv; end
                                end else if (r_op == snd_pkg::OP_STATUS) begin
                                    n_stb = bv; n_last = bv; n_pcnt = r_retry;
                                end else begin
                                    ev_v = 1'b1; ev_val = bv; ev_off = r_tot;
                                    n_tot = r_tot + 16'd1;
                                end
                                if (n_cxl == '0) begin n_ph = snd_pkg::PH_GAP; n_div = '0; end
                            end
                        end
                    end
                end
            end
            snd_pkg::PH_GAP: begin
                n_div = r_div + 8'd1;
                if (n_div >= hl) begin
                    n_div = '0;
                    case (r_op)
                        snd_pkg::OP_ID: begin
                            if (r_att == 2'd0) ok = r_stb == snd_pkg::ID_A;
                            else if (r_att == 2'd1) ok = r_stb == snd_pkg::ID_B;
                            else ok = r_stb == snd_pkg::ID_B || r_stb == snd_pkg::ID_A;
                            if (ok) np = 1'b1;
                            else if (r_att < 2'd2) begin
                                n_att = r_att + 2'd1;
                                tx = 1'b1; tx_op = snd_pkg::OP_ID; tx_n = 13'd2;
                            end else begin
                                n_rs = snd_pkg::RS_ERR; n_err = snd_pkg::ER_NODET;
                                n_ph = snd_pkg::PH_IDLE;
                            end
                        end
                        snd_pkg::OP_LOAD: begin n_retry = '0; poll = 1'b1; end
                        snd_pkg::OP_STATUS: begin
                            if (r_stb[5:4] == 2'b10 || !r_stb[0]) begin
                                tx = 1'b1; tx_op = snd_pkg::OP_CACHE; tx_n = 13'(r_pbl);
                            end else begin
                                n_ph = snd_pkg::PH_WAIT; n_wait = cfg.poll_wait_ticks;
                            end
                        end
                        default: adv = 1'b1;
                    endcase
                end
            end
            snd_pkg::PH_WAIT: begin
                if (r_wait > 24'd1) n_wait = r_wait - 24'd1;
                else begin
                    n_wait = '0; n_retry = r_retry + 10'd1; poll = 1'b1;
                end
            end
            snd_pkg::PH_FILL: begin
                ev_v = 1'b1; ev_val = 8'hFF; ev_off = r_tot; n_tot = r_tot + 16'd1;
                n_pbl = (r_pbl != '0) ? r_pbl - PW'(1) : r_pbl;
                if (n_pbl == '0) adv = 1'b1;
            end
            default: n_ph = snd_pkg::PH_IDLE;
        endcase

        if (poll) begin
            if (n_retry >= cfg.poll_limit) begin
                n_pcnt = n_retry; n_rs = snd_pkg::RS_ERR; n_err = snd_pkg::ER_TIMEOUT;
                n_ph = snd_pkg::PH_IDLE;
            end else begin
                tx = 1'b1; tx_op = snd_pkg::OP_STATUS; tx_n = 13'd1;
            end
        end
        if (adv) begin
            addr_np = r_addr + AW'(r_chunk);
            rem_np = r_rem - 16'(r_chunk);
            n_addr = addr_np; n_rem = rem_np; np = 1'b1;
        end
        if (np) begin
            if (rem_np == '0 || addr_np >= AW'(snd_pkg::DEVICE_BYTES)) begin
                n_rs = snd_pkg::RS_DONE; n_err = snd_pkg::ER_OK; n_ph = snd_pkg::PH_IDLE;
            end else begin
                ch = PW'(snd_pkg::PAGE_BYTES) - PW'(addr_np[CW-1:0]);
                if (32'(ch) > 32'(rem_np)) ch = PW'(rem_np);
                n_chunk = ch; n_pbl = ch;
                want = addr_np + AW'(cfg.read_bias);
                if (want >= AW'(snd_pkg::DEVICE_BYTES)) n_ph = snd_pkg::PH_FILL;
                else begin
                    n_row = 16'(want >> CW);
                    tx = 1'b1; tx_op = snd_pkg::OP_LOAD; tx_n = '0;
                end
            end
        end
        if (tx) begin
            n_op = tx_op; n_ph = snd_pkg::PH_CMD; n_cbi = '0; n_bit = '0; n_div = '0;
            n_sec = 1'b0; n_cxl = tx_n; n_xi = '0;
            n_sh = cmd_byte(tx_op, 2'd0, n_row, n_addr[CW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= snd_pkg::PH_IDLE; r_op <= snd_pkg::OP_ID; r_sh <= '0; r_div <= '0;
            r_stb <= '0; r_last <= '0; r_bit <= '0; r_cbi <= '0; r_wait <= '0;
            r_addr <= '0; r_rem <= '0; r_tot <= '0; r_pbl <= '0; r_chunk <= '0;
            r_retry <= '0; r_pcnt <= '0; r_att <= '0; r_rs <= snd_pkg::RS_IDLE;
            r_err <= snd_pkg::ER_OK; r_xi <= '0; r_row <= '0; r_sec <= 1'b0;
            r_cxl <= '0; r_ov <= 1'b0; r_out <= '0;
        end else begin
            if (m_axis_tready) r_ov <= 1'b0;
            if (take) begin
                r_ph <= n_ph; r_op <= n_op; r_sh <= n_sh; r_div <= n_div; r_stb <= n_stb;
                r_last <= n_last; r_bit <= n_bit; r_cbi <= n_cbi; r_wait <= n_wait;
                r_addr <= n_addr; r_rem <= n_rem; r_tot <= n_tot; r_pbl <= n_pbl;
                r_chunk <= n_chunk; r_retry <= n_retry; r_pcnt <= n_pcnt; r_att <= n_att;
                r_rs <= n_rs; r_err <= n_err; r_xi <= n_xi; r_row <= n_row;
                r_sec <= n_sec; r_cxl <= n_cxl; r_ov <= 1'b1;
                r_out <= {5'd0, n_tot, n_pcnt, n_last, n_err, n_rs, ev_off, ev_val, ev_v,
                          o_drv, o_io1, o_sck, o_cs};
            end
        end
    end

    `SND_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))
    `SND_ASSERT_IMP(a_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `SND_ASSERT_IMP(a_bytes, i_clk, i_rst_n, 1'b1,
                    r_tot <= 16'(snd_pkg::BUFFER_BYTES))
    `SND_ASSERT_IMP(a_drive, i_clk, i_rst_n, r_ph == snd_pkg::PH_CMD,
                    r_op != snd_pkg::OP_CACHE || o_drv)
endmodule

// ----- tb/spi_nand_dump_controller_test.sv -----
// Testbench for the SPI NAND dump controller: flash-side responder, tick predictor and checker
module spi_nand_dump_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] bytes_read;
        logic [9:0]  poll_count;
        logic [7:0]  last_status;
        logic [1:0]  error_code;
        logic [1:0]  run_state;
        logic [15:0] byte_offset;
        logic [7:0]  byte_value;
        logic        byte_valid;
        logic        io1_drive;
        logic        io1_out;
        logic        serial_clock;
        logic        chip_select_n;
    } t_tick_out;

    typedef struct {
        int unsigned start_a, count, bias, half, wait_t, limit;
        int unsigned id_ok, busy;
        bit          write_regs, check_end;
        snd_pkg::t_run end_run;
        snd_pkg::t_err end_err;
    } t_run_row;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [0] start_req, [1] io0_in, [2] io1_in
    logic        m_axis_tvalid, m_axis_tready;
    logic [71:0] m_axis_tdata;   // chip_select_n, serial_clock, io1_out, io1_drive, byte_valid,
                                 // byte_value, byte_offset, run_state, error_code, last_status,
                                 // poll_count, bytes_read, zero pad
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    spi_nand_dump_controller uut (.*);

    // predictor state
    int unsigned r_start, r_count, r_bias, r_half, r_wait, r_limit;
    snd_pkg::t_phase ph;
    snd_pkg::t_op    op;
    int unsigned sh, bc, cbi, td, wc, addr, rem, pbl, rc, da, sb;
    int unsigned half2, xl, xi, chunk, row, rs, ec, ls, pc, tot;
    int unsigned ev_v, ev_val, ev_off;

    // flash responder
    int unsigned id_ok, busy_left;
    logic [7:0]  id_tgt, st_tgt;
    bit          noise_on, want_start, feed, hold_req;
    int unsigned src_idle, dst_idle, hold_cnt;

    t_tick_out   expq[$];
    int unsigned n_err, n_items, n_runs, n_bytes;

    function automatic int unsigned hl();
        return r_half != 0 ? r_half : 1;
    endfunction

    function automatic int unsigned cmdb(int unsigned idx);
        int unsigned col;
        col = addr % snd_pkg::PAGE_BYTES;
        idx &= 3;
        case (op)
            snd_pkg::OP_ID:     return idx == 0 ? snd_pkg::CMD_ID : 0;
            snd_pkg::OP_LOAD:   return idx == 0 ? snd_pkg::CMD_LOAD : idx == 1 ? 0 :
                                       idx == 2 ? (row >> 8) & 255 : row & 255;
            snd_pkg::OP_STATUS: return idx == 0 ? snd_pkg::CMD_STATUS : snd_pkg::REG_STATUS;
            default:            return idx == 0 ? snd_pkg::CMD_CACHE :
                                       idx == 1 ? (col >> 8) & 255 :
                                       idx == 2 ? col & 255 : 0;
        endcase
    endfunction

    function automatic int unsigned cmdn();
        if (op == snd_pkg::OP_ID) return da == 2 ? 2 : 1;
        if (op == snd_pkg::OP_STATUS) return 2;
        return 4;
    endfunction

    function automatic void start_txn(snd_pkg::t_op o, int unsigned n);
        logic [7:0] r;
        op = o; ph = snd_pkg::PH_CMD; cbi = 0; bc = 0; td = 0; half2 = 0;
        xl = n; xi = 0; sh = cmdb(0);
        r = 8'($urandom_range(0, 255));
        if (o == snd_pkg::OP_ID) begin
            if (da == id_ok)
                id_tgt = (da == 1 || (da == 2 && r[0])) ? snd_pkg::ID_B : snd_pkg::ID_A;
            else
                id_tgt = (r == snd_pkg::ID_A || r == snd_pkg::ID_B) ? r ^ 8'h01 : r;
        end else if (o == snd_pkg::OP_STATUS) begin
            if (busy_left > 0) begin
                busy_left--;
                st_tgt = (r & 8'hCF) | 8'h01;
            end else begin
                st_tgt = r[7] ? (r & 8'hFE) : ((r & 8'hCF) | 8'h20);
            end
        end
    endfunction

    function automatic void stop_run(int unsigned s, int unsigned c);
        rs = s; ec = c; ph = snd_pkg::PH_IDLE;
    endfunction

    function automatic void emit(int unsigned v);
        ev_v = 1; ev_val = v & 255; ev_off = tot & 16'hFFFF;
        tot = (tot + 1) & 16'hFFFF;
    endfunction

    function automatic void next_page();
        int unsigned want;
        if (rem == 0 || addr >= snd_pkg::DEVICE_BYTES) begin
            stop_run(snd_pkg::RS_DONE, snd_pkg::ER_OK);
            return;
        end
        chunk = snd_pkg::PAGE_BYTES - addr % snd_pkg::PAGE_BYTES;
        if (chunk > rem) chunk = rem;
        pbl = chunk;
        want = addr + r_bias;
        if (want >= snd_pkg::DEVICE_BYTES) begin
            ph = snd_pkg::PH_FILL;
        end else begin
            row = (want / snd_pkg::PAGE_BYTES) & 16'hFFFF;
            start_txn(snd_pkg::OP_LOAD, 0);
        end
    endfunction

    function automatic void advance_page();
        addr += chunk;
        rem -= chunk;
        next_page();
    endfunction

    function automatic void poll_step();
        if (rc >= r_limit) begin
            pc = rc;
            stop_run(snd_pkg::RS_ERR, snd_pkg::ER_TIMEOUT);
        end else begin
            start_txn(snd_pkg::OP_STATUS, 1);
        end
    endfunction

    function automatic void dispatch();
        bit ok;
        case (op)
            snd_pkg::OP_ID: begin
                if (da == 0) ok = sb == snd_pkg::ID_A;
                else if (da == 1) ok = sb == snd_pkg::ID_B;
                else ok = sb == snd_pkg::ID_B || sb == snd_pkg::ID_A;
                if (ok) begin
                    next_page();
                end else if (da < 2) begin
                    da++;
                    start_txn(snd_pkg::OP_ID, 2);
                end else begin
                    stop_run(snd_pkg::RS_ERR, snd_pkg::ER_NODET);
                end
            end
            snd_pkg::OP_LOAD: begin
                rc = 0;
                poll_step();
            end
            snd_pkg::OP_STATUS: begin
                if ((sb & 8'h30) == 8'h20 || (sb & 1) == 0) begin
                    start_txn(snd_pkg::OP_CACHE, pbl);
                end else begin
                    ph = snd_pkg::PH_WAIT;
                    wc = r_wait;
                end
            end
            default: advance_page();
        endcase
    endfunction

    function automatic void byte_done(int unsigned v);
        if (op == snd_pkg::OP_ID) begin
            if (xi == 0) begin
                sb = v; ls = v;
            end
        end else if (op == snd_pkg::OP_STATUS) begin
            sb = v; ls = v; pc = rc;
        end else begin
            emit(v);
        end
    endfunction

    function automatic void shift_tick(logic io0, logic io1);
        bit legacy, dual;
        legacy = op == snd_pkg::OP_ID && da == 2;
        dual = op == snd_pkg::OP_CACHE;
        td++;
        if (td < hl()) return;
        td = 0;
        if (!half2) begin
            if (ph == snd_pkg::PH_READ && legacy) sh = ((sh << 1) | io0) & 255;
            half2 = 1;
            return;
        end
        half2 = 0;
        if (ph == snd_pkg::PH_CMD) begin
            sh = (sh << 1) & 255;
            bc++;
            if (bc < 8) return;
            bc = 0;
            cbi++;
            if (cbi < cmdn()) begin
                sh = cmdb(cbi);
            end else if (xl == 0) begin
                ph = snd_pkg::PH_GAP; td = 0;
            end else begin
                ph = snd_pkg::PH_READ; sh = 0;
            end
            return;
        end
        if (dual) sh = ((sh << 2) | (io0 << 1) | io1) & 255;
        else if (!legacy) sh = ((sh << 1) | io0) & 255;
        bc++;
        if (bc < (dual ? 4 : 8)) return;
        bc = 0;
        byte_done(sh);
        sh = 0;
        xl--;
        xi++;
        if (xl == 0) begin
            ph = snd_pkg::PH_GAP; td = 0;
        end
    endfunction

    function automatic void tick_reset();
        r_start = 0; r_count = 0; r_bias = 131072; r_half = 4; r_wait = 40000; r_limit = 1000;
        ph = snd_pkg::PH_IDLE; op = snd_pkg::OP_ID;
        sh = 0; bc = 0; cbi = 0; td = 0; wc = 0; addr = 0; rem = 0; pbl = 0; rc = 0; da = 0;
        sb = 0; half2 = 0; xl = 0; xi = 0; chunk = 0; row = 0;
        rs = snd_pkg::RS_IDLE; ec = snd_pkg::ER_OK; ls = 0; pc = 0; tot = 0;
    endfunction

    function automatic t_tick_out tick_predict(logic [7:0] d);
        t_tick_out r;
        bit active;
        active = ph == snd_pkg::PH_CMD || ph == snd_pkg::PH_READ;
        r = '0;
        r.chip_select_n = !active;
        r.serial_clock = active ? half2[0] : 1'b0;
        r.io1_out = ph == snd_pkg::PH_CMD ? sh[7] : 1'b0;
        r.io1_drive = !(ph == snd_pkg::PH_READ && op == snd_pkg::OP_CACHE);
        ev_v = 0; ev_val = 0; ev_off = 0;
        case (ph)
            snd_pkg::PH_IDLE: begin
                if (d[0]) begin
                    want_start = 0;
                    rs = snd_pkg::RS_RUN; ec = snd_pkg::ER_OK;
                    ls = 0; pc = 0; tot = 0; rc = 0; sb = 0; da = 0;
                    addr = r_start;
                    rem = r_count > snd_pkg::BUFFER_BYTES ? snd_pkg::BUFFER_BYTES : r_count;
                    start_txn(snd_pkg::OP_ID, 3);
                end
            end
            snd_pkg::PH_CMD, snd_pkg::PH_READ: shift_tick(d[1], d[2]);
            snd_pkg::PH_GAP: begin
                td++;
                if (td >= hl()) begin
                    td = 0;
                    dispatch();
                end
            end
            snd_pkg::PH_WAIT: begin
                if (wc > 1) begin
                    wc--;
                end else begin
                    wc = 0;
                    rc = (rc + 1) & 10'h3FF;
                    poll_step();
                end
            end
            default: begin
                emit(8'hFF);
                if (pbl > 0) pbl--;
                if (pbl == 0) advance_page();
            end
        endcase
        r.byte_valid = ev_v[0];
        r.byte_value = ev_val[7:0];
        r.byte_offset = ev_off[15:0];
        r.run_state = rs[1:0];
        r.error_code = ec[1:0];
        r.last_status = ls[7:0];
        r.poll_count = pc[9:0];
        r.bytes_read = tot[15:0];
        return r;
    endfunction

    // flash side: answer reads with the planned identity and status bytes
    function automatic logic [7:0] next_tick();
        logic [7:0] d;
        d = '0;
        d[1] = 1'($urandom_range(0, 1));
        d[2] = 1'($urandom_range(0, 1));
        if (ph == snd_pkg::PH_IDLE) d[0] = want_start;
        else d[0] = noise_on && $urandom_range(0, 19) == 0;
        if (ph == snd_pkg::PH_READ && !(noise_on && $urandom_range(0, 99) < 8)) begin
            if (op == snd_pkg::OP_ID && xi == 0) d[1] = id_tgt[7 - bc];
            else if (op == snd_pkg::OP_STATUS) d[1] = st_tgt[7 - bc];
        end
        return d;
    endfunction

    function automatic void chk(string name, int unsigned e, int unsigned a);
        if (e != a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            n_err++;
        end
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("spi_nand_dump_controller_test: errors");
        $finish;
    end

    // sender
    initial begin
        bit acc;
        forever begin
            @(posedge i_clk);
            acc = s_axis_tvalid && s_axis_tready;
            if (acc) begin
                expq.push_back(tick_predict(s_axis_tdata));
                n_items++;
            end
            if (!s_axis_tvalid || acc) begin
                if (feed && $urandom_range(0, 99) >= src_idle) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_tick();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_tick_out e, a;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                a = m_axis_tdata[66:0];
                if (expq.size() == 0) begin
                    $error("output item with nothing expected");
                    n_err++;
                end else begin
                    e = expq.pop_front();
                    chk("chip_select_n", e.chip_select_n, a.chip_select_n);
                    chk("serial_clock", e.serial_clock, a.serial_clock);
                    chk("io1_out", e.io1_out, a.io1_out);
                    chk("io1_drive", e.io1_drive, a.io1_drive);
                    chk("byte_valid", e.byte_valid, a.byte_valid);
                    chk("byte_value", e.byte_value, a.byte_value);
                    chk("byte_offset", e.byte_offset, a.byte_offset);
                    chk("run_state", e.run_state, a.run_state);
                    chk("error_code", e.error_code, a.error_code);
                    chk("last_status", e.last_status, a.last_status);
                    chk("poll_count", e.poll_count, a.poll_count);
                    chk("bytes_read", e.bytes_read, a.bytes_read);
                    if (e.byte_valid) n_bytes++;
                end
            end
            if (hold_req) begin
                hold_req <= 1'b0;
                hold_cnt <= 400;
                m_axis_tready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= $urandom_range(0, 99) >= dst_idle;
            end
        end
    end

    task automatic reg_write(snd_pkg::t_reg r, int unsigned v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {r, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            snd_pkg::RG_START: r_start = v & 27'h7FFFFFF;
            snd_pkg::RG_COUNT: r_count = v & 16'hFFFF;
            snd_pkg::RG_BIAS:  r_bias = v & 27'h7FFFFFF;
            snd_pkg::RG_HALF:  r_half = v & 8'hFF;
            snd_pkg::RG_WAIT:  r_wait = v & 24'hFFFFFF;
            default:           r_limit = v & 10'h3FF;
        endcase
    endtask

    task automatic drain();
        feed = 0;
        while (s_axis_tvalid || expq.size() != 0) @(posedge i_clk);
    endtask

    task automatic dump_run(t_run_row w, bit long_hold);
        drain();
        if (w.write_regs) begin
            reg_write(snd_pkg::RG_START, w.start_a);
            reg_write(snd_pkg::RG_COUNT, w.count);
            reg_write(snd_pkg::RG_BIAS, w.bias);
            reg_write(snd_pkg::RG_HALF, w.half);
            reg_write(snd_pkg::RG_WAIT, w.wait_t);
            reg_write(snd_pkg::RG_LIMIT, w.limit);
        end
        id_ok = w.id_ok;
        busy_left = w.busy;
        want_start = 1;
        feed = 1;
        if (long_hold) hold_req = 1;
        do @(posedge i_clk); while (want_start || ph != snd_pkg::PH_IDLE);
        drain();
        n_runs++;
        if (w.check_end) begin
            chk("final run_state", w.end_run, rs);
            chk("final error_code", w.end_err, ec);
        end
    endtask

    t_run_row rows[$];

    initial begin
        t_run_row w;
        int unsigned r;
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0;
        m_axis_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        feed = 0; want_start = 0; hold_req = 0; hold_cnt = 0; noise_on = 0;
        src_idle = 37; dst_idle = 71;
        n_err = 0; n_items = 0; n_runs = 0; n_bytes = 0;
        id_ok = 0; busy_left = 0; id_tgt = '0; st_tgt = '0;
        tick_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // start addr, count, bias, half, wait, limit, id attempt, busy polls, write, check
        rows.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, snd_pkg::RS_DONE, snd_pkg::ER_OK});
        rows.push_back('{0, 4, 0, 1, 2, 5, 0, 1, 1, 0, snd_pkg::RS_DONE, snd_pkg::ER_OK});
        rows.push_back('{32'h100, 3, 32'h20000, 0, 1, 3, 1, 0, 1, 0,
                         snd_pkg::RS_DONE, snd_pkg::ER_OK});
        rows.push_back('{32'h7FE, 5, 0, 2, 0, 4, 2, 2, 1, 0, snd_pkg::RS_DONE, snd_pkg::ER_OK});
        rows.push_back('{0, 4, 0, 1, 1, 3, 3, 0, 1, 1, snd_pkg::RS_ERR, snd_pkg::ER_NODET});
        rows.push_back('{0, 4, 0, 1, 1, 0, 0, 0, 1, 1, snd_pkg::RS_ERR, snd_pkg::ER_TIMEOUT});
        rows.push_back('{0, 4, 0, 1, 0, 2, 0, 9, 1, 1, snd_pkg::RS_ERR, snd_pkg::ER_TIMEOUT});
        rows.push_back('{32'h7FFFFFF, 16, 32'h7FFFFFF, 1, 3, 1, 0, 0, 1, 1,
                         snd_pkg::RS_DONE, snd_pkg::ER_OK});
        rows.push_back('{32'h7FFF000, 0, 0, 1, 3, 1, 0, 0, 1, 1,
                         snd_pkg::RS_DONE, snd_pkg::ER_OK});
        rows.push_back('{32'h7FFFFF0, 40, 32'h7FFFFFF, 1, 3, 1, 1, 0, 1, 1,
                         snd_pkg::RS_DONE, snd_pkg::ER_OK});
        rows.push_back('{0, 65535, 32'h7FFFFFF, 1, 5, 1, 0, 0, 1, 1,
                         snd_pkg::RS_DONE, snd_pkg::ER_OK});
        rows.push_back('{32'h5A5, 1, 32'h7FF0000, 255, 24'hFFFFFF, 1023, 0, 0, 1, 1,
                         snd_pkg::RS_DONE, snd_pkg::ER_OK});
        rows.push_back('{32'h3FF, 6, 32'h1234567, 3, 2, 1, 2, 1, 1, 1,
                         snd_pkg::RS_ERR, snd_pkg::ER_TIMEOUT});
        foreach (rows[i]) dump_run(rows[i], 0);

        noise_on = 1;
        for (int m = 0; m < 3; m++) begin
            src_idle = m == 0 ? 37 : m == 1 ? 71 : 0;
            dst_idle = m == 0 ? 71 : m == 1 ? 37 : 0;
            for (int k = 0; k < 40; k++) begin
                r = $urandom_range(0, 9);
                w.start_a = r < 7 ? $urandom_range(0, 32'h7FFFFFF)
                                  : 32'h7FFF800 + $urandom_range(0, 32'h7FF);
                w.count = r == 9 ? $urandom_range(0, 65535) % 40 : $urandom_range(0, 12);
                r = $urandom_range(0, 9);
                w.bias = r < 4 ? 32'h20000 : r < 6 ? 0 : $urandom_range(0, 32'h7FFFFFF);
                w.half = $urandom_range(0, 3);
                w.wait_t = $urandom_range(0, 4);
                w.limit = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6);
                w.id_ok = $urandom_range(0, 3);
                w.busy = $urandom_range(0, w.limit + 1);
                w.write_regs = 1;
                w.check_end = 0;
                w.end_run = snd_pkg::RS_DONE;
                w.end_err = snd_pkg::ER_OK;
                dump_run(w, m == 0 && k == 1);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("%0d dump runs, %0d tick items, %0d bytes delivered; detect fallbacks,",
                 n_runs, n_items, n_bytes);
        $display("busy polls, timeouts, top-of-device fill and saturated counts exercised");
        if (n_err == 0 && expq.size() == 0)
            $display("spi_nand_dump_controller_test: clean");
        else
            $display("spi_nand_dump_controller_test: errors");
        $finish;
    end
endmodule
